/* hw/rtl/bmws_pkg.sv */
// Shared types and constants for the best-match weighted score block.
// Used by bmws_colmem, bmws_acc, bmws_div and best_match_weighted_score.
`default_nettype none

package bmws_pkg;

    localparam int MAX_COLUMNS_DEF = 64;

    localparam int SCORE_W  = 18;
    localparam int WEIGHT_W = 17;
    localparam int PROD_W   = 36;
    localparam int WSUM_W   = 48;
    localparam int WTSUM_W  = 32;
    localparam int ENTRY_W  = SCORE_W + WEIGHT_W;

    // Numerator of the rounding division: magnitude plus half the divisor.
    localparam int NUM_W     = WSUM_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic signed [SCORE_W-1:0] SCORE_MIN          = 18'sh20000;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX          = 18'sh1FFFF;
    localparam logic signed [SCORE_W-1:0] NO_WEIGHT_STRENGTH = 18'sh36000;

    localparam logic signed [WSUM_W-1:0] WSUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [WSUM_W-1:0] WSUM_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic                       valid;
        logic signed [SCORE_W-1:0]  score;
        logic        [WEIGHT_W-1:0] weight;
    } t_acc_in;

endpackage

`default_nettype wire

/* hw/rtl/bmws_colmem.sv */
// Column best memory with read-compare-write pipeline and same-entry forwarding.
// Depends on bmws_pkg.
`default_nettype none

module bmws_colmem #(
    parameter int MAX_COLUMNS = bmws_pkg::MAX_COLUMNS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire bmws_pkg::t_acc_in  i_cell,
    input  wire [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] i_cell_addr,
    input  wire                     i_cell_take,
    input  wire                     i_sweep_rd,
    input  wire [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] i_sweep_addr,
    output bmws_pkg::t_acc_in       o_sweep
);
    import bmws_pkg::*;

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [ENTRY_W-1:0] r_mem [MAX_COLUMNS];
    logic [ENTRY_W-1:0] r_rdata;
    logic [ENTRY_W-1:0] r_fwd_data;
    logic               r_fwd_hit;
    logic               r_sweep_v;

    logic                       r_s1_valid;
    logic                       r_s1_take;
    logic [AW-1:0]              r_s1_addr;
    logic signed [SCORE_W-1:0]  r_s1_score;
    logic        [WEIGHT_W-1:0] r_s1_weight;

    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [ENTRY_W-1:0]        cur_entry;
    logic signed [SCORE_W-1:0] cur_score;
    logic                      we;

    assign rd_en   = i_cell.valid | i_sweep_rd;
    assign rd_addr = i_sweep_rd ? i_sweep_addr : i_cell_addr;

    // A write landing on the same edge as a read of that entry is forwarded.
    assign cur_entry = r_fwd_hit ? r_fwd_data : r_rdata;
    assign cur_score = $signed(cur_entry[ENTRY_W-1:WEIGHT_W]);
    assign we        = r_s1_valid && (r_s1_take || (r_s1_score > cur_score));

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_s1_addr] <= {r_s1_score, r_s1_weight};
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_sweep_v  <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= i_cell.valid;
            r_sweep_v  <= i_sweep_rd;
            r_fwd_hit  <= we && i_cell.valid && (i_cell_addr == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= {r_s1_score, r_s1_weight};
        if (i_cell.valid) begin
            r_s1_take   <= i_cell_take;
            r_s1_addr   <= i_cell_addr;
            r_s1_score  <= i_cell.score;
            r_s1_weight <= i_cell.weight;
        end
    end

    assign o_sweep.valid  = r_sweep_v;
    assign o_sweep.score  = $signed(r_rdata[ENTRY_W-1:WEIGHT_W]);
    assign o_sweep.weight = r_rdata[WEIGHT_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/bmws_acc.sv */
// Saturating accumulators for score times significance and for significance.
// Depends on bmws_pkg.
`default_nettype none

module bmws_acc (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_clear,
    input  wire bmws_pkg::t_acc_in            i_in,
    output logic signed [bmws_pkg::WSUM_W-1:0] o_wsum,
    output logic [bmws_pkg::WTSUM_W-1:0]      o_wtsum,
    output logic                              o_busy
);
    import bmws_pkg::*;

    logic                       r_a_valid;
    logic signed [PROD_W-1:0]   r_prod;
    logic        [WEIGHT_W-1:0] r_a_w;
    logic signed [WSUM_W-1:0]   r_wsum;
    logic        [WTSUM_W-1:0]  r_wtsum;

    logic signed [WSUM_W:0]   wsum_ext;
    logic        [WTSUM_W:0]  wtsum_ext;
    logic signed [WSUM_W-1:0] n_wsum;
    logic        [WTSUM_W-1:0] n_wtsum;

    assign wsum_ext  = (WSUM_W + 1)'(r_wsum) + (WSUM_W + 1)'(r_prod);
    assign wtsum_ext = {1'b0, r_wtsum} + (WTSUM_W + 1)'(r_a_w);

    always_comb begin
        if (wsum_ext[WSUM_W] != wsum_ext[WSUM_W-1]) begin
            n_wsum = wsum_ext[WSUM_W] ? WSUM_MIN : WSUM_MAX;
        end else begin
            n_wsum = wsum_ext[WSUM_W-1:0];
        end
        n_wtsum = wtsum_ext[WTSUM_W] ? '1 : wtsum_ext[WTSUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_in.score * $signed({1'b0, i_in.weight});
        r_a_w  <= i_in.weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_a_valid <= 1'b0;
            r_wsum    <= '0;
            r_wtsum   <= '0;
        end else begin
            r_a_valid <= i_in.valid;
            if (r_a_valid) begin
                r_wsum  <= n_wsum;
                r_wtsum <= n_wtsum;
            end
        end
    end

    assign o_wsum  = r_wsum;
    assign o_wtsum = r_wtsum;
    assign o_busy  = r_a_valid;

endmodule

`default_nettype wire

/* hw/rtl/bmws_div.sv */
// Bit-serial rounding divider: weighted sum over significance sum, saturated.
// Depends on bmws_pkg.
`default_nettype none

module bmws_div (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire signed [bmws_pkg::WSUM_W-1:0]  i_wsum,
    input  wire [bmws_pkg::WTSUM_W-1:0]        i_wtsum,
    output logic                               o_done,
    output logic signed [bmws_pkg::SCORE_W-1:0] o_strength
);
    import bmws_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_PREP = 2'd1;
    localparam logic [1:0] D_ITER = 2'd2;
    localparam logic [1:0] D_FIN  = 2'd3;

    logic [1:0]          r_state;
    logic [DCNT_W-1:0]   r_cnt;
    logic                r_neg;
    logic [WSUM_W-1:0]   r_mag;
    logic [NUM_W-1:0]    r_num;
    logic [WTSUM_W-1:0]  r_rem;
    logic [SCORE_W-1:0]  r_q;
    logic                r_ovf;

    logic [WTSUM_W:0]    shifted;
    logic                ge;
    logic [WTSUM_W:0]    diff;

    assign shifted = {r_rem, r_num[NUM_W-1]};
    assign ge      = shifted >= {1'b0, i_wtsum};
    assign diff    = shifted - {1'b0, i_wtsum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: if (i_start) r_state <= D_PREP;
                D_PREP: r_state <= D_ITER;
                D_ITER: if (r_cnt == DCNT_W'(DIV_STEPS - 1)) r_state <= D_FIN;
                D_FIN:  r_state <= D_IDLE;
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                r_neg <= i_wsum[WSUM_W-1];
                r_mag <= i_wsum[WSUM_W-1] ? WSUM_W'(-i_wsum) : WSUM_W'(i_wsum);
            end
            D_PREP: begin
                // Adding half the divisor gives round to nearest, ties away from zero.
                r_num <= {1'b0, r_mag} + NUM_W'(i_wtsum >> 1);
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
                r_cnt <= '0;
            end
            D_ITER: begin
                r_rem <= ge ? diff[WTSUM_W-1:0] : shifted[WTSUM_W-1:0];
                r_num <= r_num << 1;
                r_q   <= {r_q[SCORE_W-2:0], ge};
                r_ovf <= r_ovf | r_q[SCORE_W-1];
                r_cnt <= r_cnt + 1'b1;
            end
            D_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_neg) begin
            if (r_ovf || (r_q > {1'b1, {(SCORE_W-1){1'b0}}})) begin
                o_strength = SCORE_MIN;
            end else begin
                o_strength = $signed(-r_q);
            end
        end else begin
            if (r_ovf || r_q[SCORE_W-1]) begin
                o_strength = SCORE_MAX;
            end else begin
                o_strength = $signed(r_q);
            end
        end
    end

    assign o_done = (r_state == D_FIN);

endmodule

`default_nettype wire

/* hw/rtl/best_match_weighted_score.sv */
// Best-match weighted score, top level.
// Cells of a score matrix enter row by row on i_valid/o_ready, one transfer per
// cell, with score, significance and the row_end / matrix_end markers. The block
// keeps the best cell of each row in registers and the best cell of each column
// in a one-port-read, one-port-write memory (MAX_COLUMNS entries) that is read,
// compared and written back in the next cycle, with forwarding on back-to-back
// hits. Within a matrix a cell is accepted every cycle.
// After the matrix_end transfer o_ready stays low while the column bests are
// swept into the accumulators (one column per cycle) and the bit-serial divider
// runs 49 steps; the divider is skipped when the significance sum is zero, and
// the result is then the no-weight strength with o_no_weight set.
// One result goes out on o_valid/i_ready per matrix.
// When the receiver stalls, the result sits in the output register and the next
// matrix is accepted at once; its own result waits until that register frees.
// Reset clears the row, column and sum state; the column memory is not cleared,
// entries past the widest row seen are treated as empty.
// Depends on bmws_pkg, bmws_colmem, bmws_acc and bmws_div.
`default_nettype none

module best_match_weighted_score #(
    parameter int MAX_COLUMNS = bmws_pkg::MAX_COLUMNS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire signed [bmws_pkg::SCORE_W-1:0]   i_score,
    input  wire [bmws_pkg::WEIGHT_W-1:0]         i_significance,
    input  wire                                  i_row_end,
    input  wire                                  i_matrix_end,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic signed [bmws_pkg::SCORE_W-1:0]  o_strength,
    output logic                                 o_no_weight
);
    import bmws_pkg::*;

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int PW = $clog2(MAX_COLUMNS + 1);

    localparam logic [2:0] S_RUN   = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                 r_state;
    logic [PW-1:0]              r_col_pos;
    logic [PW-1:0]              r_col_total;
    logic [PW-1:0]              r_sw;
    logic signed [SCORE_W-1:0]  r_row_score;
    logic        [WEIGHT_W-1:0] r_row_weight;
    logic signed [SCORE_W-1:0]  r_res_strength;
    logic                       r_res_nw;
    logic                       r_out_valid;
    logic signed [SCORE_W-1:0]  r_out_strength;
    logic                       r_out_nw;

    logic                       accept;
    logic                       in_col;
    logic                       take_row;
    logic                       row_done;
    logic [PW-1:0]              pos_inc;
    logic signed [SCORE_W-1:0]  row_s;
    logic        [WEIGHT_W-1:0] row_w;
    t_acc_in                    row_acc;
    t_acc_in                    col_cell;
    t_acc_in                    sweep;
    t_acc_in                    acc_in;
    logic                       sweep_rd;
    logic                       load_out;
    logic                       acc_clear;
    logic                       div_start;
    logic                       div_done;
    logic signed [SCORE_W-1:0]  div_strength;
    logic signed [WSUM_W-1:0]   wsum;
    logic        [WTSUM_W-1:0]  wtsum;
    logic                       acc_busy;

    assign o_ready  = (r_state == S_RUN);
    assign accept   = i_valid && o_ready;
    assign in_col   = r_col_pos < PW'(MAX_COLUMNS);
    assign take_row = (r_col_pos == '0) || (i_score > r_row_score);
    assign row_s    = take_row ? i_score : r_row_score;
    assign row_w    = take_row ? i_significance : r_row_weight;
    assign row_done = i_row_end | i_matrix_end;
    assign pos_inc  = in_col ? r_col_pos + 1'b1 : r_col_pos;

    assign row_acc.valid  = accept && row_done;
    assign row_acc.score  = row_s;
    assign row_acc.weight = row_w;

    assign col_cell.valid  = accept && in_col;
    assign col_cell.score  = i_score;
    assign col_cell.weight = i_significance;

    assign acc_in   = row_acc.valid ? row_acc : sweep;
    assign sweep_rd = (r_state == S_SWEEP) && (r_sw < r_col_total);
    assign load_out = (r_state == S_OUT) && (!r_out_valid || i_ready);
    assign acc_clear = load_out;
    assign div_start = (r_state == S_FLUSH) && !sweep.valid && !acc_busy && (wtsum != '0);

    bmws_colmem #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_colmem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell       (col_cell),
        .i_cell_addr  (r_col_pos[AW-1:0]),
        .i_cell_take  (r_col_pos >= r_col_total),
        .i_sweep_rd   (sweep_rd),
        .i_sweep_addr (r_sw[AW-1:0]),
        .o_sweep      (sweep)
    );

    bmws_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (acc_clear),
        .i_in    (acc_in),
        .o_wsum  (wsum),
        .o_wtsum (wtsum),
        .o_busy  (acc_busy)
    );

    bmws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_wsum     (wsum),
        .i_wtsum    (wtsum),
        .o_done     (div_done),
        .o_strength (div_strength)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_col_pos    <= '0;
            r_col_total  <= '0;
            r_sw         <= '0;
            r_row_score  <= SCORE_MIN;
            r_row_weight <= '0;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (accept) begin
                        if (row_done) begin
                            r_row_score  <= SCORE_MIN;
                            r_row_weight <= '0;
                            r_col_pos    <= '0;
                            if (pos_inc > r_col_total) begin
                                r_col_total <= pos_inc;
                            end
                        end else begin
                            r_row_score  <= row_s;
                            r_row_weight <= row_w;
                            r_col_pos    <= pos_inc;
                        end
                        if (i_matrix_end) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    // The last cell's column write lands here, before the sweep reads.
                    r_sw    <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (sweep_rd) begin
                        r_sw <= r_sw + 1'b1;
                    end else begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!sweep.valid && !acc_busy) begin
                        r_state <= (wtsum == '0) ? S_OUT : S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_col_total <= '0;
                        r_state     <= S_RUN;
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FLUSH) && (wtsum == '0)) begin
            r_res_strength <= NO_WEIGHT_STRENGTH;
            r_res_nw       <= 1'b1;
        end else if (div_done) begin
            r_res_strength <= div_strength;
            r_res_nw       <= 1'b0;
        end
        if (load_out) begin
            r_out_strength <= r_res_strength;
            r_out_nw       <= r_res_nw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_strength  = r_out_strength;
    assign o_no_weight = r_out_nw;

    a_acc_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(row_acc.valid && sweep.valid))
        else $error("row best and column sweep reached the accumulator together");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_col_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col_pos <= PW'(MAX_COLUMNS)) && (r_col_total <= PW'(MAX_COLUMNS)))
        else $error("column counters exceed the column limit");

    a_sweep_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (($past(r_state) == S_DRAIN) || ($past(r_state) == S_SWEEP)))
        else $error("column sweep started without draining the last write");

endmodule

`default_nettype wire
